### src/kcl_pkg.sv
// Shared types and constants for the keypad code lock.
`timescale 1ns / 1ps
`default_nettype none
package kcl_pkg;

   localparam int KEY_W    = 4;
   localparam int STATUS_W = 4;
   localparam int DIGITS_W = 3;
   localparam int FAIL_W   = 8;
   localparam int MODE_W   = 2;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 3;

   // key codes
   localparam logic [KEY_W-1:0] KEY_NINE = 4'd9;
   localparam logic [KEY_W-1:0] KEY_A    = 4'd10;
   localparam logic [KEY_W-1:0] KEY_B    = 4'd11;
   localparam logic [KEY_W-1:0] KEY_C    = 4'd12;
   localparam logic [KEY_W-1:0] KEY_D    = 4'd13;
   localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;

   // register map
   localparam logic [ADDR_W-1:0] REG_LOCK_THRESHOLD = 3'd0;
   localparam logic [FAIL_W-1:0] LOCK_THRESHOLD_RST = 8'd4;
   localparam logic [FAIL_W-1:0] FAIL_MAX           = 8'd255;

   typedef enum logic [STATUS_W-1:0] {
      ST_TAKEN     = 4'd0,
      ST_IGNORED   = 4'd1,
      ST_REJECTED  = 4'd2,
      ST_CLEARED   = 4'd3,
      ST_CORRECT   = 4'd4,
      ST_WRONG     = 4'd5,
      ST_LOCKED    = 4'd6,
      ST_ENTER_OLD = 4'd7,
      ST_ENTER_NEW = 4'd8,
      ST_CHANGED   = 4'd9,
      ST_SAME_CODE = 4'd10
   } status_type;

   typedef struct packed {
      status_type                status;
      logic [DIGITS_W-1:0]       digits_entered;
      logic [FAIL_W-1:0]         wrong_count;
      logic [MODE_W-1:0]         lock_mode;
   } result_type;

endpackage
`default_nettype wire

### src/kcl_if.sv
// Valid/ready channel interfaces for key words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface kcl_req_if;
   logic                     valid;
   logic                     ready;
   logic [kcl_pkg::KEY_W-1:0] key_code;

   modport source (output valid, output key_code, input ready);
   modport sink   (input valid, input key_code, output ready);
endinterface

interface kcl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [kcl_pkg::STATUS_W-1:0] status;
   logic [kcl_pkg::DIGITS_W-1:0] digits_entered;
   logic [kcl_pkg::FAIL_W-1:0]   wrong_count;
   logic [kcl_pkg::MODE_W-1:0]   lock_mode;

   modport source (output valid, output status, output digits_entered,
                   output wrong_count, output lock_mode, input ready);
   modport sink   (input valid, input status, input digits_entered,
                   input wrong_count, input lock_mode, output ready);
endinterface
`default_nettype wire

### src/kcl_csr.sv
// APB-style register block holding the lock threshold.
`timescale 1ns / 1ps
`default_nettype none
module kcl_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [kcl_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [kcl_pkg::DATA_W-1:0]    pwdata,
   output      logic [kcl_pkg::DATA_W-1:0]    prdata,
   output      logic                          pready,
   output      logic [kcl_pkg::FAIL_W-1:0]    lock_threshold
);
   logic [kcl_pkg::FAIL_W-1:0] thresh_ff;
   logic [kcl_pkg::FAIL_W-1:0] thresh_in;
   logic                       sel_thresh;

   // word index is paddr[2]; byte offset bits are ignored
   assign sel_thresh = (paddr[2] == kcl_pkg::REG_LOCK_THRESHOLD[2]);
   assign pready     = 1'b1;

   always_comb begin
      thresh_in = thresh_ff;
      if (psel && penable && pwrite && sel_thresh) begin
         thresh_in = pwdata[kcl_pkg::FAIL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= kcl_pkg::LOCK_THRESHOLD_RST;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   assign prdata = sel_thresh
                   ? {{(kcl_pkg::DATA_W-kcl_pkg::FAIL_W){1'b0}}, thresh_ff}
                   : '0;
   assign lock_threshold = thresh_ff;
endmodule
`default_nettype wire

### src/kcl_engine.sv
// Lock state and single-pass next-state logic for one key.
`timescale 1ns / 1ps
`default_nettype none
module kcl_engine #(
   parameter int CODE_DIGITS = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step_en,
   input  wire logic [kcl_pkg::KEY_W-1:0]   key_code,
   input  wire logic [kcl_pkg::FAIL_W-1:0]  lock_threshold,
   output      kcl_pkg::result_type         result
);
   localparam int CNT_W = $clog2(CODE_DIGITS + 1);

   typedef enum logic [kcl_pkg::MODE_W-1:0] {
      MODE_NORMAL = 2'd0,
      MODE_VERIFY = 2'd1,
      MODE_NEW    = 2'd2
   } mode_type;

   typedef logic [CODE_DIGITS-1:0][kcl_pkg::KEY_W-1:0] code_type;

   code_type                    entry_ff, entry_in, entry_wr;
   code_type                    stored_ff, stored_in;
   code_type                    old_ff, old_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [kcl_pkg::FAIL_W-1:0]  fail_ff, fail_in, fail_sat;
   mode_type                    mode_ff, mode_in;
   kcl_pkg::status_type         status, wrong_status;
   logic                        full, last;
   logic [CNT_W+2:0]            count_ext;

   // entry with the current key written at the next free place
   always_comb begin
      entry_wr = entry_ff;
      for (int k = 0; k < CODE_DIGITS; k++) begin
         if (count_ff == CNT_W'(k)) begin
            entry_wr[k] = key_code;
         end
      end
   end

   assign full     = (count_ff >= CNT_W'(CODE_DIGITS));
   assign last     = (count_ff == CNT_W'(CODE_DIGITS - 1));
   assign fail_sat = (fail_ff == kcl_pkg::FAIL_MAX) ? fail_ff : fail_ff + 8'd1;
   assign wrong_status = (fail_sat > lock_threshold) ? kcl_pkg::ST_LOCKED
                                                     : kcl_pkg::ST_WRONG;

   always_comb begin
      entry_in  = entry_ff;
      count_in  = count_ff;
      stored_in = stored_ff;
      old_in    = old_ff;
      fail_in   = fail_ff;
      mode_in   = mode_ff;
      status    = kcl_pkg::ST_IGNORED;
      if (step_en) begin
         priority if (key_code >= kcl_pkg::KEY_STAR) begin
            status = kcl_pkg::ST_REJECTED;
         end else if (key_code == kcl_pkg::KEY_B) begin
            status = kcl_pkg::ST_IGNORED;
         end else if (key_code == kcl_pkg::KEY_C) begin
            count_in = '0;
            status   = kcl_pkg::ST_CLEARED;
         end else if (key_code <= kcl_pkg::KEY_NINE) begin
            if (full) begin
               status = kcl_pkg::ST_IGNORED;
            end else begin
               entry_in = entry_wr;
               count_in = count_ff + CNT_W'(1);
               status   = kcl_pkg::ST_TAKEN;
               if (last && mode_ff == MODE_VERIFY) begin
                  count_in = '0;
                  if (entry_wr == stored_ff) begin
                     fail_in = '0;
                     old_in  = entry_wr;
                     mode_in = MODE_NEW;
                     status  = kcl_pkg::ST_ENTER_NEW;
                  end else begin
                     fail_in = fail_sat;
                     mode_in = MODE_NORMAL;
                     status  = wrong_status;
                  end
               end else if (last && mode_ff == MODE_NEW) begin
                  count_in = '0;
                  if (entry_wr == old_ff) begin
                     mode_in = MODE_VERIFY;
                     status  = kcl_pkg::ST_SAME_CODE;
                  end else begin
                     stored_in = entry_wr;
                     mode_in   = MODE_NORMAL;
                     status    = kcl_pkg::ST_CHANGED;
                  end
               end
            end
         end else if (mode_ff == MODE_VERIFY || mode_ff == MODE_NEW) begin
            status = kcl_pkg::ST_IGNORED;
         end else if (key_code == kcl_pkg::KEY_A) begin
            count_in = '0;
            mode_in  = MODE_VERIFY;
            status   = kcl_pkg::ST_ENTER_OLD;
         end else if (key_code == kcl_pkg::KEY_D) begin
            if (full) begin
               count_in = '0;
               if (entry_ff == stored_ff) begin
                  fail_in = '0;
                  status  = kcl_pkg::ST_CORRECT;
               end else begin
                  fail_in = fail_sat;
                  status  = wrong_status;
               end
            end else begin
               status = kcl_pkg::ST_IGNORED;
            end
         end else begin
            status = kcl_pkg::ST_IGNORED;
         end
      end
   end

   // entry and old code are only read once fully written: no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      old_ff   <= old_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         stored_ff <= '0;
         fail_ff   <= '0;
         mode_ff   <= MODE_NORMAL;
      end else begin
         count_ff  <= count_in;
         stored_ff <= stored_in;
         fail_ff   <= fail_in;
         mode_ff   <= mode_in;
      end
   end

   assign count_ext = {3'b000, count_in};

   always_comb begin
      result.status         = status;
      result.digits_entered = count_ext[kcl_pkg::DIGITS_W-1:0];
      result.wrong_count    = fail_in;
      result.lock_mode      = mode_in;
   end
endmodule
`default_nettype wire

### src/keypad_code_lock.sv
// Top level of the keypad code lock: channel registers, engine, registers.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  req_if  | in  | valid/ready        | key_code[3:0]
//  rsp_if  | out | valid/ready        | status, digits_entered, wrong_count, lock_mode
//  csr     | in  | psel/penable/pready| paddr[2:0], pwdata/prdata[31:0]
//
//  One key word per cycle unless results stall. A key waits in the key register,
//  then the engine updates lock state and loads the result register in one pass.
//  Synchronous active-high reset: empty pipeline, threshold 4, stored code 0000.
//  A stalled result holds the result register; the key register still takes a
//  word when the result register frees up in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module keypad_code_lock #(
   parameter int CODE_DIGITS = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   kcl_req_if.sink                          req_if,
   kcl_rsp_if.source                        rsp_if,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [kcl_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [kcl_pkg::DATA_W-1:0]  pwdata,
   output      logic [kcl_pkg::DATA_W-1:0]  prdata,
   output      logic                        pready
);
   // key register
   logic                        key_vld_ff, key_vld_in;
   logic [kcl_pkg::KEY_W-1:0]   key_ff, key_in;
   // result register
   logic                        rsp_vld_ff, rsp_vld_in;
   kcl_pkg::result_type         rsp_ff, rsp_in;

   logic                        advance;   // result register can load
   logic                        step_en;   // engine consumes the held key
   logic [kcl_pkg::FAIL_W-1:0]  lock_threshold;
   kcl_pkg::result_type         result;

   kcl_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .lock_threshold (lock_threshold)
   );

   kcl_engine #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .key_code       (key_ff),
      .lock_threshold (lock_threshold),
      .result         (result)
   );

   assign advance      = !rsp_vld_ff || rsp_if.ready;
   assign step_en      = key_vld_ff && advance;
   assign req_if.ready = !key_vld_ff || advance;

   always_comb begin
      key_vld_in = key_vld_ff;
      key_in     = key_ff;
      if (req_if.ready) begin
         key_vld_in = req_if.valid;
         key_in     = req_if.key_code;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (advance) begin
         rsp_vld_in = key_vld_ff;
         rsp_in     = result;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         key_vld_ff <= key_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_if.valid          = rsp_vld_ff;
   assign rsp_if.status         = rsp_ff.status;
   assign rsp_if.digits_entered = rsp_ff.digits_entered;
   assign rsp_if.wrong_count    = rsp_ff.wrong_count;
   assign rsp_if.lock_mode      = rsp_ff.lock_mode;
endmodule
`default_nettype wire

### tb/sv/kcl_lock_checker.sv
// Result predictor and scoreboard for the keypad code lock.
`timescale 1ns / 1ps
module kcl_lock_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   kcl_req_if                              keys,
   kcl_rsp_if                              results,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic                       pready,
   input  wire logic [kcl_pkg::ADDR_W-1:0] paddr,
   input  wire logic [kcl_pkg::DATA_W-1:0] pwdata,
   output int                              fail_count,
   output int                              pending,
   output logic                            at_rest,
   output logic [3:0][3:0]                 live_code
);
   import kcl_pkg::*;

   localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VERIFY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NEW    = 2'd2;

   // lock state as the predictor sees it
   logic [3:0][3:0]     typed;
   logic [DIGITS_W-1:0] typed_n;
   logic [3:0][3:0]     secret;
   logic [3:0][3:0]     secret_was;
   logic [FAIL_W-1:0]   misses;
   logic [FAIL_W-1:0]   max_misses;
   logic [MODE_W-1:0]   lock_state;

   result_type          due[$];

   assign at_rest   = (lock_state == MODE_NORMAL);
   assign live_code = secret;

   function automatic status_type note_miss();
      if (misses != FAIL_MAX)
         misses = misses + 1'b1;
      if (misses > max_misses)
         return ST_LOCKED;
      return ST_WRONG;
   endfunction

   function automatic result_type press(input logic [KEY_W-1:0] key);
      result_type r;
      status_type st;
      st = ST_IGNORED;
      if (key >= KEY_STAR) begin
         st = ST_REJECTED;
      end else if (key == KEY_B) begin
         st = ST_IGNORED;
      end else if (key == KEY_C) begin
         typed   = '0;
         typed_n = '0;
         st      = ST_CLEARED;
      end else if (key <= KEY_NINE) begin
         if (typed_n < 4) begin
            typed[typed_n] = key;
            typed_n        = typed_n + 1'b1;
            st             = ST_TAKEN;
            if (typed_n == 4 && lock_state == MODE_VERIFY) begin
               typed_n = '0;
               if (typed == secret) begin
                  misses     = '0;
                  secret_was = typed;
                  lock_state = MODE_NEW;
                  st         = ST_ENTER_NEW;
               end else begin
                  st         = note_miss();
                  lock_state = MODE_NORMAL;
               end
            end else if (typed_n == 4 && lock_state == MODE_NEW) begin
               typed_n = '0;
               if (typed == secret_was) begin
                  lock_state = MODE_VERIFY;
                  st         = ST_SAME_CODE;
               end else begin
                  secret     = typed;
                  lock_state = MODE_NORMAL;
                  st         = ST_CHANGED;
               end
            end
         end
      end else if (lock_state == MODE_VERIFY || lock_state == MODE_NEW) begin
         st = ST_IGNORED;
      end else if (key == KEY_A) begin
         typed_n    = '0;
         lock_state = MODE_VERIFY;
         st         = ST_ENTER_OLD;
      end else if (key == KEY_D && typed_n == 4) begin
         typed_n = '0;
         if (typed == secret) begin
            misses = '0;
            st     = ST_CORRECT;
         end else begin
            st = note_miss();
         end
      end
      r.status         = st;
      r.digits_entered = typed_n;
      r.wrong_count    = misses;
      r.lock_mode      = lock_state;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         typed      = '0;
         typed_n    = '0;
         secret     = '0;
         secret_was = '0;
         misses     = '0;
         max_misses = LOCK_THRESHOLD_RST;
         lock_state = MODE_NORMAL;
         fail_count = 0;
         due.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == REG_LOCK_THRESHOLD)
            max_misses = pwdata[FAIL_W-1:0];
         if (keys.valid && keys.ready)
            due.push_back(press(keys.key_code));
         if (results.valid && results.ready) begin
            if (due.size() == 0) begin
               $display("%0t: result word with none expected, got status %0d",
                        $time, results.status);
               fail_count++;
            end else begin
               want = due.pop_front();
               check_field("status", 8'(want.status), 8'(results.status));
               check_field("digits_entered", 8'(want.digits_entered),
                           8'(results.digits_entered));
               check_field("wrong_count", want.wrong_count, results.wrong_count);
               check_field("lock_mode", 8'(want.lock_mode), 8'(results.lock_mode));
            end
         end
      end
      pending = due.size();
   end

endmodule

### tb/sv/keypad_code_lock_tb.sv
// Stimulus and verdict for the keypad code lock testbench.
`timescale 1ns / 1ps
module keypad_code_lock_tb;
   import kcl_pkg::*;

   typedef logic [3:0][3:0] code_type;

   // not in the package: only the stimulus needs it
   localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

   // Cycles with no word moving on either channel before giving up. Worst
   // legal quiet spell is a register write plus the drain at a phase end and
   // a run of random stalls, so this is generous.
   localparam int WATCHDOG_LIMIT = 1000;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   kcl_req_if key_ch ();
   kcl_rsp_if res_ch ();

   int        fail_count;
   int        pending;
   logic      at_rest;
   code_type  live_code;
   bit        steady;          // set: neither side idles
   int        keys_sent;
   int        settings_used;
   int        quiet_cycles;

   keypad_code_lock uut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (key_ch),
      .rsp_if  (res_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   kcl_lock_checker lock_watch (
      .clock      (clock),
      .reset      (reset),
      .keys       (key_ch),
      .results    (res_ch),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending),
      .at_rest    (at_rest),
      .live_code  (live_code)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result side back-pressure: stalls about a third of the time unless the
   // run is in a steady stretch.
   initial begin
      res_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         res_ch.ready <= steady || ($urandom_range(99) >= 36);
      end
   end

   // Watchdog: counts cycles in which no word is accepted anywhere.
   always @(posedge clock) begin
      if (reset || (key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles, %0d result words outstanding",
                  quiet_cycles, pending);
         $display("keypad_code_lock_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One key word. Called at a falling edge, returns at the falling edge
   // after acceptance with valid still high, so back-to-back words never
   // drop and re-raise valid in the same step.
   task automatic send_key(input logic [KEY_W-1:0] k);
      if (!steady && $urandom_range(99) < 36) begin
         key_ch.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < 36);
      end
      key_ch.valid    <= 1'b1;
      key_ch.key_code <= k;
      do @(posedge clock); while (!key_ch.ready);
      @(negedge clock);
      keys_sent++;
   endtask

   // Four digits, first digit first. Noisy mode slips in keys that change
   // nothing (B, star, hash) between digits.
   task automatic send_code(input code_type c, input bit noisy);
      for (int i = 0; i < 4; i++) begin
         if (noisy && $urandom_range(99) < 10)
            send_key($urandom_range(1) ? KEY_B : 4'($urandom_range(KEY_HASH, KEY_STAR)));
         send_key(c[i]);
      end
   endtask

   function automatic code_type other_code(input code_type avoid);
      code_type c;
      do begin
         for (int i = 0; i < 4; i++)
            c[i] = 4'($urandom_range(9));
      end while (c == avoid);
      return c;
   endfunction

   // Stop sending and wait until every result word is back, then let the
   // two-stage pipe settle.
   task automatic drain();
      key_ch.valid <= 1'b0;
      @(negedge clock);
      wait (pending == 0);
      repeat (4) @(negedge clock);
   endtask

   // Threshold write: setup then access phase, only with no key words in flight.
   // Upper data bits are random; only the low byte is the register.
   task automatic set_threshold(input logic [FAIL_W-1:0] v);
      drain();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= REG_LOCK_THRESHOLD;
      pwdata  <= ($urandom() & 32'hFFFF_FF00) | DATA_W'(v);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_used++;
   endtask

   // Bring the lock back to normal entry. Four digits unlike the stored code
   // end a change in either stage: a failed old code, or a real change.
   task automatic back_to_rest();
      while (!at_rest) begin
         send_key(KEY_C);
         send_code(other_code(live_code), 1'b0);
      end
   endtask

   // Code change sequence with random content: sometimes a bad old code,
   // ignored A/D keys mid-change, a same-code retry, or a cleared partial.
   task automatic code_change();
      back_to_rest();
      send_key(KEY_A);
      if ($urandom_range(99) < 15)
         send_key($urandom_range(1) ? KEY_A : KEY_D);
      if ($urandom_range(99) < 20) begin
         send_code(other_code(live_code), 1'b1);
      end else begin
         send_code(live_code, 1'b1);
         if ($urandom_range(99) < 25) begin
            send_code(live_code, 1'b1);   // same code, back to verifying
            send_code(live_code, 1'b1);
         end
         if ($urandom_range(99) < 15) begin
            send_key(4'($urandom_range(9)));
            send_key(KEY_C);
         end
         send_code(other_code(live_code), 1'b1);
      end
   endtask

   // Mostly well-formed checks and changes, the rest short/overfull entries
   // and raw noise over all sixteen keys.
   task automatic run_random(input int n);
      int stop_at;
      int pick;
      stop_at = keys_sent + n;
      while (keys_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            back_to_rest();
            send_key(KEY_C);
            if (pick < 25)
               send_code(live_code, 1'b1);
            else if (pick < 45)
               send_code(other_code(live_code), 1'b1);
            else
               repeat ($urandom_range(6)) send_key(4'($urandom_range(9)));
            send_key(KEY_D);
         end else if (pick < 80) begin
            code_change();
         end else begin
            repeat ($urandom_range(6, 1)) send_key(4'($urandom_range(15)));
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      steady          = 1'b0;
      key_ch.valid    = 1'b0;
      key_ch.key_code = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      keys_sent       = 0;
      settings_used   = 0;
      quiet_cycles    = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset threshold, stored code 0000.
      send_key(KEY_STAR);               // rejected
      send_key(KEY_HASH);               // rejected
      send_key(KEY_B);                  // no action
      send_key(KEY_D);                  // check with empty entry
      send_code(16'h0000, 1'b0);
      send_key(KEY_NINE);               // entry full, dropped
      send_key(KEY_D);                  // correct
      send_key(KEY_A);                  // change: enter old
      send_key(KEY_D);                  // ignored mid-change
      send_key(KEY_C);                  // clear while verifying
      send_code(16'h9999, 1'b0);        // bad old code, back to normal
      send_key(KEY_A);
      send_code(16'h0000, 1'b0);        // old code good
      send_code(16'h4321, 1'b0);        // new code taken

      // Threshold 0: the first miss already locks.
      set_threshold(8'd0);
      run_random(120);

      // Threshold 255: a run of misses stays below the lock point.
      set_threshold(FAIL_MAX);
      back_to_rest();
      repeat (16) begin
         send_code(other_code(live_code), 1'b0);
         send_key(KEY_D);
      end
      steady = 1'b1;
      run_random(120);
      steady = 1'b0;

      // Small random threshold, with a full drain halfway through.
      set_threshold(8'($urandom_range(16, 1)));
      run_random(70);
      drain();
      run_random(70);

      set_threshold(8'($urandom_range(255)));
      run_random(110);

      drain();
      $display("covered %0d key words over %0d threshold writes (0 and 255 among them),",
               keys_sent, settings_used);
      $display("wrong checks, locked reports, code changes, clears and stalled results");
      if (fail_count == 0 && pending == 0)
         $display("keypad_code_lock_tb: PASS");
      else
         $display("keypad_code_lock_tb: FAIL");
      $finish;
   end

endmodule
